FILE: hw/rtl/aavr_pkg.sv
// shared constants, types and tables for the axis-angle vector rotation block
package aavr_pkg;

    localparam int unsigned CordicIters = 24;
    localparam int unsigned LaneCount   = 3;

    typedef logic signed [31:0] t_word;
    typedef logic signed [33:0] t_cord;
    // q1.30 value with headroom: (1 - cos) reaches 2.0 and row entries about 3.0
    typedef logic signed [33:0] t_q30;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [65:0] t_acc;

    localparam t_cord CordicStart = 34'sd652032874;
    localparam t_q30  Q30One      = 34'sd1073741824;

    // per-element bundle travelling down the pipeline
    typedef struct packed {
        t_word vx;
        t_word vy;
        t_word vz;
        t_q30  ax;
        t_q30  ay;
        t_q30  az;
    } t_vec_bundle;

    // lane result into the merging stage
    typedef struct packed {
        t_word value;
        logic  clip;
    } t_lane_out;

    function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051D;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh00000A2F9;
            5'd15: v = 34'sh00000517C;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A2F;
            5'd19: v = 34'sh000000517;
            5'd20: v = 34'sh00000028B;
            5'd21: v = 34'sh000000145;
            5'd22: v = 34'sh0000000A2;
            5'd23: v = 34'sh000000051;
            5'd24: v = 34'sh000000028;
            5'd25: v = 34'sh000000014;
            5'd26: v = 34'sh00000000A;
            5'd27: v = 34'sh000000005;
            5'd28: v = 34'sh000000002;
            5'd29: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // q1.30 product rounded to nearest (floor of +half)
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        t_prod p;
        p = t_prod'(a) * t_prod'(b) + t_prod'(64'sd536870912);
        return t_q30'(p >>> 30);
    endfunction

    function automatic t_q30 clamp_unit(input t_word a);
        t_q30 r;
        if (a > Q30One) begin
            r = Q30One;
        end else if (a < -Q30One) begin
            r = -Q30One;
        end else begin
            r = t_q30'(a);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/aavr_cordic.sv
// pipelined rotation-mode cordic producing sine and cosine, one stage per step
module aavr_cordic (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  aavr_pkg::t_word      i_angle,
    output aavr_pkg::t_q30       o_cos,
    output aavr_pkg::t_q30       o_sin
);
    import aavr_pkg::*;

    t_cord r_x   [CordicIters+1];
    t_cord r_y   [CordicIters+1];
    t_cord r_z   [CordicIters+1];
    logic  r_flip[CordicIters+1];
    t_cord n_z0;
    logic  n_flip0;

    // quadrant fold into [-pi/2, pi/2]
    always_comb begin
        n_z0    = t_cord'(i_angle);
        n_flip0 = 1'b0;
        if (n_z0 > t_cord'(Q30One)) begin
            n_z0    = n_z0 - 34'sd2147483648;
            n_flip0 = 1'b1;
        end else if (n_z0 < -t_cord'(Q30One)) begin
            n_z0    = n_z0 + 34'sd2147483648;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CordicStart;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
        end
    end

    // one micro-rotation per stage
    for (genvar g = 0; g < CordicIters; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_lut(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_lut(5'(g));
                end
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    assign o_cos = r_flip[CordicIters] ? -t_q30'(r_x[CordicIters]) : t_q30'(r_x[CordicIters]);
    assign o_sin = r_flip[CordicIters] ? -t_q30'(r_y[CordicIters]) : t_q30'(r_y[CordicIters]);
endmodule

FILE: hw/rtl/aavr_lane.sv
// one matrix row lane: builds a row and takes its dot product with the vector
module aavr_lane (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [1:0]          i_row,
    input  aavr_pkg::t_q30      i_cos,
    input  aavr_pkg::t_q30      i_sin,
    input  aavr_pkg::t_q30      i_mx,
    input  aavr_pkg::t_q30      i_my,
    input  aavr_pkg::t_q30      i_mz,
    input  aavr_pkg::t_vec_bundle i_b,
    output aavr_pkg::t_lane_out o_res
);
    import aavr_pkg::*;

    t_q30  n_m0, n_m1, n_m2;
    t_q30  r_m0, r_m1, r_m2;
    t_word r_v0, r_v1, r_v2;
    t_prod r_p0, r_p1, r_p2;
    t_acc  n_hi, n_lo, n_sum;
    t_lane_out r_res;

    function automatic t_lane_out o_res_n(input t_acc v);
        t_lane_out r;
        r.clip = 1'b0;
        if (v > t_acc'(66'sd2147483647)) begin
            r.value = 32'sh7FFFFFFF;
            r.clip  = 1'b1;
        end else if (v < -t_acc'(66'sd2147483648)) begin
            r.value = 32'sh80000000;
            r.clip  = 1'b1;
        end else begin
            r.value = t_word'(v);
        end
        return r;
    endfunction

    // row entries
    always_comb begin
        case (i_row)
            2'd0: begin
                n_m0 = i_cos + mul30(i_b.ax, i_mx);
                n_m1 = mul30(i_b.ax, i_my) - mul30(i_b.az, i_sin);
                n_m2 = mul30(i_b.ax, i_mz) + mul30(i_b.ay, i_sin);
            end
            2'd1: begin
                n_m0 = mul30(i_b.ax, i_my) + mul30(i_b.az, i_sin);
                n_m1 = i_cos + mul30(i_b.ay, i_my);
                n_m2 = mul30(i_b.ay, i_mz) - mul30(i_b.ax, i_sin);
            end
            default: begin
                n_m0 = mul30(i_b.ax, i_mz) - mul30(i_b.ay, i_sin);
                n_m1 = mul30(i_b.ay, i_mz) + mul30(i_b.ax, i_sin);
                n_m2 = i_cos + mul30(i_b.az, i_mz);
            end
        endcase
    end

    // exact sum then one rounding
    always_comb begin
        n_hi  = t_acc'(r_p0) + t_acc'(r_p1) + t_acc'(r_p2);
        n_lo  = n_hi + t_acc'(66'sd536870912);
        n_sum = n_lo >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0 <= n_m0; r_m1 <= n_m1; r_m2 <= n_m2;
            r_v0 <= i_b.vx; r_v1 <= i_b.vy; r_v2 <= i_b.vz;
            r_p0 <= t_prod'(r_m0) * t_prod'(r_v0);
            r_p1 <= t_prod'(r_m1) * t_prod'(r_v1);
            r_p2 <= t_prod'(r_m2) * t_prod'(r_v2);
            r_res <= o_res_n(n_sum);
        end
    end

    assign o_res = r_res;
endmodule

FILE: hw/rtl/axis_angle_vector_rotation.sv
// top level: axis-angle rotation of a q16.16 vector with saturation flag
//
// Input channel i_valid/o_stall carries one item per cycle while o_stall is
// low: a vector, an angle (2^31 units = pi) and a unit axis in q1.30. Output
// channel o_valid/i_stall returns the rotated vector and a clip flag, one item
// for each input item. Throughput is one item per cycle while the receiver
// does not stall. The path is registered in the angle fold register, the
// cordic stages, one stage for the (1 - cos) terms, two for row build and
// products, one for the lane sum and saturation and one for the merge into
// the output register.
// Three row lanes work side by side and a merge stage joins their results.
// The whole pipeline advances together; when i_stall holds a waiting output
// item, the pipeline freezes and o_stall rises only if the output register is
// full and the receiver stalls, so items keep flowing otherwise.
// Synchronous active-low reset clears all valid bits; data is not cleared.
module axis_angle_vector_rotation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  aavr_pkg::t_word     i_vec_x,
    input  aavr_pkg::t_word     i_vec_y,
    input  aavr_pkg::t_word     i_vec_z,
    input  aavr_pkg::t_word     i_turn_angle,
    input  aavr_pkg::t_word     i_axis_x,
    input  aavr_pkg::t_word     i_axis_y,
    input  aavr_pkg::t_word     i_axis_z,
    output logic                o_valid,
    input  logic                i_stall,
    output aavr_pkg::t_word     o_rot_x,
    output aavr_pkg::t_word     o_rot_y,
    output aavr_pkg::t_word     o_rot_z,
    output logic                o_clipped
);
    import aavr_pkg::*;

    localparam int unsigned Depth = CordicIters + 5;

    logic        en;
    logic        r_vld [Depth];
    t_vec_bundle r_b   [CordicIters+2];
    t_vec_bundle n_b;
    t_q30        cos_w, sin_w;
    t_q30        r_c, r_s, r_mx, r_my, r_mz;
    t_lane_out   lane_res [LaneCount];
    logic        r_ovld;
    t_word       r_rx, r_ry, r_rz;
    logic        r_clip;

    // pipeline advances unless the output holds an item that is stalled
    assign en      = !(r_ovld && i_stall);
    assign o_stall = !en;

    always_comb begin
        n_b.vx = i_vec_x; n_b.vy = i_vec_y; n_b.vz = i_vec_z;
        n_b.ax = clamp_unit(i_axis_x);
        n_b.ay = clamp_unit(i_axis_y);
        n_b.az = clamp_unit(i_axis_z);
    end

    aavr_cordic u_cordic (
        .i_clk(i_clk), .i_en(en),
        .i_angle(i_turn_angle), .o_cos(cos_w), .o_sin(sin_w)
    );

    // bundle delay line alongside the cordic
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b[0] <= n_b;
            for (int k = 1; k < CordicIters + 2; k++) begin
                r_b[k] <= r_b[k-1];
            end
        end
    end

    // (1 - cos) scaled by each axis component
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c  <= cos_w;
            r_s  <= sin_w;
            r_mx <= mul30(r_b[CordicIters].ax, Q30One - cos_w);
            r_my <= mul30(r_b[CordicIters].ay, Q30One - cos_w);
            r_mz <= mul30(r_b[CordicIters].az, Q30One - cos_w);
        end
    end

    for (genvar g = 0; g < LaneCount; g++) begin : g_lane
        aavr_lane u_lane (
            .i_clk(i_clk), .i_en(en), .i_row(2'(g)),
            .i_cos(r_c), .i_sin(r_s), .i_mx(r_mx), .i_my(r_my), .i_mz(r_mz),
            .i_b(r_b[CordicIters+1]), .o_res(lane_res[g])
        );
    end

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < Depth; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[Depth-1];
        end
    end

    // merge stage: lanes into the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx   <= lane_res[0].value;
            r_ry   <= lane_res[1].value;
            r_rz   <= lane_res[2].value;
            r_clip <= lane_res[0].clip | lane_res[1].clip | lane_res[2].clip;
        end
    end

    assign o_valid   = r_ovld;
    assign o_rot_x   = r_rx;
    assign o_rot_y   = r_ry;
    assign o_rot_z   = r_rz;
    assign o_clipped = r_clip;
endmodule

FILE: hw/rtl/aavr_checker.sv
// port-level checks for the rotation block and their bind
module aavr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic [31:0] o_rot_x,
    input logic o_clipped
);
    // stalled output item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rot_x) && $stable(o_clipped))
        else $error("stalled output item changed");
    // input stalls only when output is blocked
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");
    // a valid output item carries known data
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_rot_x, o_clipped}))
        else $error("valid output item has unknown bits");
    // no output right after reset
    a_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("output valid out of reset");
endmodule

bind axis_angle_vector_rotation aavr_checker u_aavr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_rot_x(o_rot_x), .o_clipped(o_clipped)
);
